// ===== src/priority_rle_cel_blitter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cel blitter checker.
// Each macro needs clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_RLE_CEL_BLITTER_ASSERT_SVH
`define PRIORITY_RLE_CEL_BLITTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRCB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cel blitter check failed");

// The consequent must hold in the cycle after the antecedent.
`define PRCB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cel blitter check failed");

`endif

// ===== src/prcb_pkg.sv =====
// ----------------------------------------------------------------------------
// prcb_pkg
// Types and codes shared by the cel blitter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package prcb_pkg;

  // Bus action codes as they arrive on the request channel.
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;
  localparam logic [1:0] ACT_CODE  = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_POS_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_PR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CEL_W     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CEL_H     = 3'd6;

  // Priority nibbles: control lines lie below this band.
  localparam logic [3:0] PRI_CTRL_LIMIT = 4'h3;
  localparam logic [3:0] PRI_FLOOR      = 4'h4;

  typedef struct packed {
    logic [1:0]  action;
    logic [14:0] pixel_addr;
    logic [7:0]  pixel_data;
    logic [7:0]  code_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       hidden;
    logic       cel_done;
  } out_t;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_READ  = 2'd1,
    OP_START = 2'd2,
    OP_CODE  = 2'd3
  } op_e;

  // One classified request waiting for the back end.
  typedef struct packed {
    op_e         op;
    logic        addr_ok;
    logic [14:0] addr;
    logic [7:0]  data;
    logic [7:0]  code;
  } cmd_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [7:0]           data;
  } cfg_wr_t;

endpackage

`default_nettype wire

// ===== src/prcb_ram.sv =====
// ----------------------------------------------------------------------------
// prcb_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module prcb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 26880
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write or read at one address per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/prcb_front.sv =====
// ----------------------------------------------------------------------------
// prcb_front
// Accepts requests, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module prcb_front #(
  parameter int unsigned STORE_SIZE = 26880
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push,
  output logic                full,
  input  wire prcb_pkg::in_t  item_i,
  output logic                cmd_valid_o,
  input  wire logic           cmd_pop_i,
  output prcb_pkg::cmd_t      cmd_o
);

  localparam int unsigned DEPTH = 2;

  prcb_pkg::cmd_t slot_q [DEPTH];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  prcb_pkg::cmd_t cmd_new;
  logic           do_push;

  // Classify the incoming request.
  always_comb begin
    cmd_new.addr    = item_i.pixel_addr;
    cmd_new.data    = item_i.pixel_data;
    cmd_new.code    = item_i.code_byte;
    cmd_new.addr_ok = (32'(item_i.pixel_addr) < 32'(STORE_SIZE));
    case (item_i.action)
      prcb_pkg::ACT_LOAD:  cmd_new.op = prcb_pkg::OP_LOAD;
      prcb_pkg::ACT_READ:  cmd_new.op = prcb_pkg::OP_READ;
      prcb_pkg::ACT_START: cmd_new.op = prcb_pkg::OP_START;
      default:             cmd_new.op = prcb_pkg::OP_CODE;
    endcase
  end

  assign full        = (count_q == 2'(DEPTH));
  assign do_push     = push && !full;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (cmd_pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (do_push && !cmd_pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!do_push && cmd_pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage carries no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

// ===== src/prcb_back.sv =====
// ----------------------------------------------------------------------------
// prcb_back
// Executes queued requests: bus access, cel decoding and priority test.
// ----------------------------------------------------------------------------
`default_nettype none

module prcb_back #(
  parameter int unsigned SCREEN_WIDTH  = 160,
  parameter int unsigned SCREEN_HEIGHT = 168
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire prcb_pkg::cfg_wr_t cfg_i,
  input  wire logic              cmd_valid_i,
  output logic                   cmd_pop_o,
  input  wire prcb_pkg::cmd_t    cmd_i,
  output logic                   empty,
  input  wire logic              pop,
  output prcb_pkg::out_t         result_o
);

  localparam int unsigned STORE_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned AW         = $clog2(STORE_SIZE);
  localparam int unsigned CUR_W      = $clog2(STORE_SIZE + 2) + 1;
  localparam int unsigned RS_W       = $clog2(STORE_SIZE + 256 * SCREEN_WIDTH + 512) + 1;
  localparam int unsigned WK_W       = $clog2(STORE_SIZE + SCREEN_WIDTH + 1);

  localparam logic signed [RS_W-1:0] RS_STORE = RS_W'(STORE_SIZE);
  localparam logic signed [RS_W-1:0] RS_WIDTH = RS_W'(SCREEN_WIDTH);
  localparam logic [WK_W-1:0]        WK_STORE = WK_W'(STORE_SIZE);
  localparam logic [WK_W-1:0]        WK_WIDTH = WK_W'(SCREEN_WIDTH);
  localparam logic signed [CUR_W-1:0] CUR_STORE = CUR_W'(STORE_SIZE);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RDATA = 6'b000010,
    S_PIX   = 6'b000100,
    S_PR    = 6'b001000,
    S_WALK  = 6'b010000,
    S_RES   = 6'b100000
  } state_e;

  // Clamp a row position into the cursor range.
  function automatic logic signed [CUR_W-1:0] clamp_rs(input logic signed [RS_W-1:0] v);
    logic signed [CUR_W-1:0] r;
    if (v < -1) begin
      r = '1;
    end else if (v > RS_STORE) begin
      r = CUR_STORE;
    end else begin
      r = CUR_W'(v);
    end
    return r;
  endfunction

  // Move the cursor one column and saturate.
  function automatic logic signed [CUR_W-1:0] step_c(input logic signed [CUR_W-1:0] c,
                                                    input logic m);
    logic signed [RS_W-1:0] t;
    t = RS_W'(c);
    t = m ? t - RS_W'(1) : t + RS_W'(1);
    return clamp_rs(t);
  endfunction

  // Configuration registers.
  logic [7:0] pos_x_q, pos_y_q, cel_w_q, cel_h_q;
  logic [3:0] spr_q, transp_q;
  logic       mirror_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q  <= 8'd0;
      pos_y_q  <= 8'd0;
      spr_q    <= 4'd0;
      transp_q <= 4'd0;
      mirror_q <= 1'b0;
      cel_w_q  <= 8'd1;
      cel_h_q  <= 8'd1;
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        prcb_pkg::REG_POS_X:     pos_x_q  <= cfg_i.data;
        prcb_pkg::REG_POS_Y:     pos_y_q  <= cfg_i.data;
        prcb_pkg::REG_SPRITE_PR: spr_q    <= cfg_i.data[3:0];
        prcb_pkg::REG_TRANSP:    transp_q <= cfg_i.data[3:0];
        prcb_pkg::REG_MIRROR:    mirror_q <= cfg_i.data[0];
        prcb_pkg::REG_CEL_W:     cel_w_q  <= cfg_i.data;
        prcb_pkg::REG_CEL_H:     cel_h_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  state_e                  state_q, state_d;
  logic signed [RS_W-1:0]  row_start_q, row_start_d;
  logic signed [CUR_W-1:0] cursor_q, cursor_d;
  logic [7:0]              rows_done_q, rows_done_d;
  logic                    hidden_q, hidden_d;
  logic                    active_q, active_d;
  logic [3:0]              count_q, count_d;
  logic [3:0]              colour_q, colour_d;
  logic [3:0]              pr_q, pr_d;
  logic [WK_W-1:0]         walk_q, walk_d;
  logic [7:0]              rd_q, rd_d;
  logic                    out_valid_q, out_valid_d;
  prcb_pkg::out_t          out_q;
  logic                    out_load;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;

  prcb_ram #(.WIDTH(8), .DEPTH(STORE_SIZE)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Start position of a cel, clamped to the screen.
  logic [7:0]             x_c, y_c;
  logic signed [RS_W-1:0] start_rs;
  always_comb begin
    x_c = (32'(pos_x_q) > 32'(SCREEN_WIDTH - 1)) ? 8'(SCREEN_WIDTH - 1) : pos_x_q;
    y_c = (32'(pos_y_q) > 32'(SCREEN_HEIGHT - 1)) ? 8'(SCREEN_HEIGHT - 1) : pos_y_q;
    start_rs = RS_W'(y_c) * RS_WIDTH + RS_W'(x_c);
    if (mirror_q) begin
      start_rs = start_rs + RS_W'(cel_w_q) - RS_W'(1);
    end
  end

  logic                   cur_in;
  logic [3:0]             v_pr, prv, epr;
  logic [WK_W-1:0]        walk_nx;
  logic                   found, at_end;
  logic signed [RS_W-1:0] rs_next;
  logic [8:0]             rows_nx;

  // Sequencer for one request at a time.
  always_comb begin
    state_d     = state_q;
    row_start_d = row_start_q;
    cursor_d    = cursor_q;
    rows_done_d = rows_done_q;
    hidden_d    = hidden_q;
    active_d    = active_q;
    count_d     = count_q;
    colour_d    = colour_q;
    pr_d        = pr_q;
    walk_d      = walk_q;
    rd_d        = rd_q;
    cmd_pop_o   = 1'b0;
    out_load    = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = '0;
    ram_wdata   = '0;
    cur_in  = !cursor_q[CUR_W-1] && (cursor_q < CUR_STORE);
    v_pr    = ram_rdata[7:4];
    prv     = (state_q == S_PR) ? v_pr : pr_q;
    found   = (v_pr >= prcb_pkg::PRI_CTRL_LIMIT);
    walk_nx = walk_q + WK_WIDTH;
    at_end  = (walk_nx >= WK_STORE);
    epr     = found ? v_pr : prcb_pkg::PRI_FLOOR;
    rs_next = row_start_q + RS_WIDTH;
    rows_nx = {1'b0, rows_done_q} + 9'd1;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          rd_d      = 8'd0;
          state_d   = S_RES;
          case (cmd_i.op)
            prcb_pkg::OP_LOAD: begin
              if (cmd_i.addr_ok) begin
                ram_we    = 1'b1;
                ram_addr  = AW'(cmd_i.addr);
                ram_wdata = cmd_i.data;
              end
            end
            prcb_pkg::OP_READ: begin
              if (cmd_i.addr_ok) begin
                ram_re   = 1'b1;
                ram_addr = AW'(cmd_i.addr);
                state_d  = S_RDATA;
              end
            end
            prcb_pkg::OP_START: begin
              row_start_d = start_rs;
              cursor_d    = clamp_rs(start_rs);
              rows_done_d = 8'd0;
              hidden_d    = 1'b1;
              active_d    = (cel_h_q != 8'd0);
            end
            prcb_pkg::OP_CODE: begin
              if (active_q) begin
                if (cmd_i.code == 8'd0) begin
                  // End of row: move to the next row start.
                  row_start_d = rs_next;
                  cursor_d    = clamp_rs(rs_next);
                  rows_done_d = rows_nx[7:0];
                  if (rows_nx >= {1'b0, cel_h_q}) begin
                    active_d = 1'b0;
                  end
                end else begin
                  colour_d = cmd_i.code[7:4];
                  count_d  = cmd_i.code[3:0];
                  state_d  = S_PIX;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_RDATA: begin
        rd_d    = ram_rdata;
        state_d = S_RES;
      end
      S_PIX: begin
        if (count_q == 4'd0) begin
          state_d = S_RES;
        end else if ((colour_q != transp_q) && cur_in) begin
          ram_re   = 1'b1;
          ram_addr = AW'(cursor_q);
          walk_d   = WK_W'(cursor_q);
          state_d  = S_PR;
        end else begin
          cursor_d = step_c(cursor_q, mirror_q);
          count_d  = count_q - 4'd1;
        end
      end
      S_PR, S_WALK: begin
        if (state_q == S_PR) begin
          pr_d = v_pr;
        end
        if (found || at_end) begin
          // Priority settled: test and plot.
          if (spr_q >= epr) begin
            ram_we    = 1'b1;
            ram_addr  = AW'(cursor_q);
            ram_wdata = {((prv < prcb_pkg::PRI_CTRL_LIMIT) ? prv : spr_q), colour_q};
            hidden_d  = 1'b0;
          end
          cursor_d = step_c(cursor_q, mirror_q);
          count_d  = count_q - 4'd1;
          state_d  = S_PIX;
        end else begin
          // Control line: look one row further down.
          walk_d   = walk_nx;
          ram_re   = 1'b1;
          ram_addr = AW'(walk_nx);
          state_d  = S_WALK;
        end
      end
      S_RES: begin
        if (!out_valid_q || pop) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_start_q <= '0;
      cursor_q    <= '0;
      rows_done_q <= 8'd0;
      hidden_q    <= 1'b1;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_start_q <= row_start_d;
      cursor_q    <= cursor_d;
      rows_done_q <= rows_done_d;
      hidden_q    <= hidden_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working payload registers.
  always_ff @(posedge clk_i) begin
    count_q  <= count_d;
    colour_q <= colour_d;
    pr_q     <= pr_d;
    walk_q   <= walk_d;
    rd_q     <= rd_d;
    if (out_load) begin
      out_q.read_data <= rd_q;
      out_q.hidden    <= hidden_q;
      out_q.cel_done  <= !active_q && (rows_done_q >= cel_h_q);
    end
  end

  assign empty    = !out_valid_q;
  assign result_o = out_q;

endmodule

`default_nettype wire

// ===== src/priority_rle_cel_blitter.sv =====
// ----------------------------------------------------------------------------
// priority_rle_cel_blitter
// Screen store with bus access and a priority-tested run-length cel blitter.
// ----------------------------------------------------------------------------
// Requests enter through push/full and results leave through empty/pop; every
// request yields exactly one result, in order. A load or start goes from idle
// to the result state; a read of a valid address passes through a read-data
// state first. A code byte steps through its run pixel by pixel: a skipped
// pixel only moves the cursor, while a tested pixel takes one read and one
// test of the single store port, plus one more read per row of the look-down
// on a control line.
// A two-entry request queue keeps accepting while the back end works, and one
// result register holds a finished result; when the receiver stalls, the
// back end waits with its next result and the queue fills, then full rises.
// Reset empties both queues, clears the cel state, sets hidden and restores
// the registers; the store contents stay undefined until loaded.
// Configuration is to be written through cfg_we_i/cfg_idx_i/cfg_data_i
// only while idle, by the user; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_rle_cel_blitter #(
  parameter int unsigned SCREEN_WIDTH  = 160,
  parameter int unsigned SCREEN_HEIGHT = 168
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             push,
  output logic                                  full,
  input  wire prcb_pkg::in_t                    item_i,
  output logic                                  empty,
  input  wire logic                             pop,
  output prcb_pkg::out_t                        result_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [prcb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [7:0]                       cfg_data_i
);

  logic              cmd_valid;
  logic              cmd_pop;
  prcb_pkg::cmd_t    cmd;
  prcb_pkg::cfg_wr_t cfg_wr;

  assign cfg_wr.we   = cfg_we_i;
  assign cfg_wr.idx  = cfg_idx_i;
  assign cfg_wr.data = cfg_data_i;

  prcb_front #(.STORE_SIZE(SCREEN_WIDTH * SCREEN_HEIGHT)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  prcb_back #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_wr),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

// ===== src/prcb_checker.sv =====
// ----------------------------------------------------------------------------
// prcb_checker
// Port-level checks for the cel blitter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "priority_rle_cel_blitter_assert.svh"

module prcb_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           push,
  input wire logic           full,
  input wire logic           empty,
  input wire logic           pop,
  input wire prcb_pkg::out_t result_o
);

  // Requests accepted whose results have not yet been taken.
  logic [2:0] pending_q;
  logic       acc_in, acc_out;

  assign acc_in  = push && !full;
  assign acc_out = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 3'd0;
    end else if (acc_in && !acc_out) begin
      pending_q <= pending_q + 3'd1;
    end else if (!acc_in && acc_out) begin
      pending_q <= pending_q - 3'd1;
    end
  end

  `PRCB_ASSERT_NEXT(a_result_waits, !empty && !pop, !empty)
  `PRCB_ASSERT_NEXT(a_result_holds, !empty && !pop, $stable(result_o))
  `PRCB_ASSERT_NOW(a_no_orphan_result, !empty, pending_q != 3'd0)
  `PRCB_ASSERT_NOW(a_full_at_capacity, pending_q == 3'd4, full)

endmodule

bind priority_rle_cel_blitter prcb_checker u_prcb_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);

`default_nettype wire

// ===== dv/priority_rle_cel_blitter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_rle_cel_blitter_test
// Self-checking bench for the priority-tested run-length cel blitter. The
// top rows of the screen store and its last corner are filled first, with a
// guard row whose priorities stop every look-down. A short table of directed
// requests then covers the corner cases. Random cels, bus loads and reads
// follow under a series of register settings, kept inside the filled rows.
// Every result is compared with a behavioural model of the store and the cel
// decoder that the bench keeps itself.
// ----------------------------------------------------------------------------
module priority_rle_cel_blitter_test;

  localparam int SW = 160;
  localparam int SH = 168;
  localparam int STORE = SW * SH;
  localparam int BAND_ROWS = 4;
  localparam int BAND = BAND_ROWS * SW;
  localparam int CORNER = 16;
  localparam int RAND_ITEMS = 770;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  prcb_pkg::in_t item_i = '0;
  logic empty;
  logic pop = 1'b0;
  prcb_pkg::out_t result_o;
  logic cfg_we_i = 1'b0;
  logic [prcb_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [7:0] cfg_data_i = '0;

  priority_rle_cel_blitter dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .item_i(item_i),
    .empty(empty), .pop(pop), .result_o(result_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Model state: store, cel decoder and registers.
  logic [7:0] scr_mem [0:STORE-1];
  int row_base, cursor;
  int unsigned rows_cnt;
  bit hid_flag, cel_on;
  logic [7:0] r_posx, r_posy, r_celw, r_celh;
  logic [3:0] r_spr, r_transp;
  logic r_mirror;

  prcb_pkg::out_t pending_results[$];
  int unsigned mismatches, n_sent, n_cels, n_drawn, n_lookdowns, n_checked;
  bit stall_req;

  function automatic int clamp_cursor_pos(int v);
    if (v < -1) return -1;
    if (v > STORE) return STORE;
    return v;
  endfunction

  // One pixel through the priority test, with the column look-down on control lines.
  function automatic void paint_pixel(int at, logic [3:0] colour);
    logic [3:0] pr, epr;
    int walk;
    if (at < 0 || at >= STORE) return;
    pr = scr_mem[at][7:4];
    if (pr < prcb_pkg::PRI_CTRL_LIMIT) begin
      n_lookdowns++;
      epr = prcb_pkg::PRI_FLOOR;
      walk = at;
      while (walk < STORE) begin
        if (scr_mem[walk][7:4] >= prcb_pkg::PRI_CTRL_LIMIT) begin
          epr = scr_mem[walk][7:4];
          break;
        end
        walk += SW;
      end
    end else begin
      epr = pr;
    end
    if (r_spr >= epr) begin
      scr_mem[at] = {(pr < prcb_pkg::PRI_CTRL_LIMIT) ? pr : r_spr, colour};
      hid_flag = 1'b0;
      n_drawn++;
    end
  endfunction

  // Applies one request to the model and returns the result it gives.
  function automatic prcb_pkg::out_t blit_request(prcb_pkg::in_t it);
    prcb_pkg::out_t res;
    int x, y, cnt;
    logic [3:0] colour;
    res = '0;
    case (prcb_pkg::op_e'(it.action))
      prcb_pkg::OP_LOAD:
        if (it.pixel_addr < STORE) scr_mem[it.pixel_addr] = it.pixel_data;
      prcb_pkg::OP_READ:
        if (it.pixel_addr < STORE) res.read_data = scr_mem[it.pixel_addr];
      prcb_pkg::OP_START: begin
        n_cels++;
        x = (r_posx > SW - 1) ? SW - 1 : int'(r_posx);
        y = (r_posy > SH - 1) ? SH - 1 : int'(r_posy);
        row_base = x + y * SW;
        if (r_mirror) row_base += int'(r_celw) - 1;
        cursor = clamp_cursor_pos(row_base);
        rows_cnt = 0;
        hid_flag = 1'b1;
        cel_on = (r_celh != 0);
      end
      default: begin
        if (cel_on) begin
          if (it.code_byte == 8'h00) begin
            row_base += SW;
            cursor = clamp_cursor_pos(row_base);
            rows_cnt++;
            if (rows_cnt >= r_celh) cel_on = 1'b0;
          end else begin
            colour = it.code_byte[7:4];
            for (cnt = it.code_byte[3:0]; cnt != 0; cnt--) begin
              if (colour != r_transp) paint_pixel(cursor, colour);
              cursor = clamp_cursor_pos(cursor + (r_mirror ? -1 : 1));
            end
          end
        end
      end
    endcase
    res.hidden = hid_flag;
    res.cel_done = !cel_on && rows_cnt >= r_celh;
    return res;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] rand_pixel();
    logic [3:0] pr;
    pr = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 2)) : 4'($urandom_range(3, 15));
    return {pr, 4'($urandom_range(0, 15))};
  endfunction

  // Pixel for a store address; the guard row never holds a control line.
  function automatic logic [7:0] band_pixel(int addr);
    if (addr >= BAND - SW && addr < BAND)
      return {4'($urandom_range(3, 15)), 4'($urandom_range(0, 15))};
    return rand_pixel();
  endfunction

  // Bus address inside the filled rows, or now and then beyond the store.
  function automatic int rand_addr();
    if ($urandom_range(0, 9) == 0) return $urandom_range(STORE, 32767);
    return $urandom_range(0, BAND - 1);
  endfunction

  function automatic prcb_pkg::in_t make_req(prcb_pkg::op_e op, int addr, int data, int code);
    prcb_pkg::in_t it;
    it.action = op;
    it.pixel_addr = 15'(addr);
    it.pixel_data = 8'(data);
    it.code_byte = 8'(code);
    return it;
  endfunction

  // Offers one request until accepted, then records its expected result.
  task automatic send_req(prcb_pkg::in_t it, bit known, prcb_pkg::out_t exp_val, bit idle_ok);
    prcb_pkg::out_t predicted;
    int g;
    push <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (full);
    predicted = blit_request(it);
    pending_results = {pending_results, (known ? exp_val : predicted)};
    n_sent++;
    g = idle_ok ? gap_len() : 0;
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // Register write once every outstanding result has come back.
  task automatic write_reg(logic [prcb_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
    push <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (3) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      prcb_pkg::REG_POS_X:     r_posx = val;
      prcb_pkg::REG_POS_Y:     r_posy = val;
      prcb_pkg::REG_SPRITE_PR: r_spr = val[3:0];
      prcb_pkg::REG_TRANSP:    r_transp = val[3:0];
      prcb_pkg::REG_MIRROR:    r_mirror = val[0];
      prcb_pkg::REG_CEL_W:     r_celw = val;
      default:                 r_celh = val;
    endcase
  endtask

  // Directed table: a row is either a register write or a request.
  typedef struct {
    bit is_cfg;
    bit known;
    logic [prcb_pkg::CFG_IDX_W-1:0] idx;
    logic [7:0] cval;
    prcb_pkg::in_t req;
    prcb_pkg::out_t exp_val;
  } dir_row_t;
  dir_row_t dir_rows[$];

  function automatic void add_row(bit is_cfg, bit known, logic [prcb_pkg::CFG_IDX_W-1:0] idx,
                                  logic [7:0] cval, prcb_pkg::in_t req,
                                  prcb_pkg::out_t exp_val);
    dir_row_t r;
    r.is_cfg = is_cfg; r.known = known; r.idx = idx; r.cval = cval;
    r.req = req; r.exp_val = exp_val;
    dir_rows = {dir_rows, r};
  endfunction

  function automatic prcb_pkg::out_t ov(int rd, bit h, bit d);
    prcb_pkg::out_t o;
    o.read_data = 8'(rd); o.hidden = h; o.cel_done = d;
    return o;
  endfunction

  // Result checker and receiver-side idling.
  int pop_idle, stall_left;
  always @(posedge clk_i) begin
    prcb_pkg::out_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        n_checked++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", result_o);
        end else begin
          want = pending_results.pop_front();
          if (result_o !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected rd=%h hid=%b done=%b got rd=%h hid=%b done=%b",
                       want.read_data, want.hidden, want.cel_done,
                       result_o.read_data, result_o.hidden, result_o.cel_done);
          end
        end
      end
      if (stall_req) begin
        stall_req = 1'b0;
        stall_left = 500;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (pop_idle > 0) begin
        pop_idle--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        pop_idle = gap_len();
      end
    end
  end

  // Main sequence.
  initial begin
    prcb_pkg::in_t it;
    int k, rows, runs, stall_at, a;
    bit stalled;
    r_posx = 0; r_posy = 0; r_spr = 0; r_transp = 0; r_mirror = 0; r_celw = 1; r_celh = 1;
    row_base = 0; cursor = 0; rows_cnt = 0; hid_flag = 1'b1; cel_on = 1'b0;
    stall_at = 300;
    stalled = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Fill the top rows and the last corner; cels and bus traffic stay there.
    for (a = 0; a < BAND; a++)
      send_req(make_req(prcb_pkg::OP_LOAD, a, band_pixel(a), 0), 1'b0, '0, 1'b0);
    for (a = STORE - CORNER; a < STORE; a++)
      send_req(make_req(prcb_pkg::OP_LOAD, a, rand_pixel(), 0), 1'b0, '0, 1'b0);
    push <= 1'b0;

    // Bus extremes, codes with no cel, a one-row cel with skipped and empty runs.
    add_row(0, 1, 0, 0, make_req(prcb_pkg::OP_READ, 32767, 0, 0), ov(0, 1, 0));
    add_row(0, 1, 0, 0, make_req(prcb_pkg::OP_LOAD, 32767, 8'hff, 0), ov(0, 1, 0));
    add_row(0, 1, 0, 0, make_req(prcb_pkg::OP_LOAD, STORE - 1, 8'hff, 0), ov(0, 1, 0));
    add_row(0, 1, 0, 0, make_req(prcb_pkg::OP_READ, STORE - 1, 0, 0), ov(8'hff, 1, 0));
    add_row(0, 1, 0, 0, make_req(prcb_pkg::OP_READ, STORE, 0, 0), ov(0, 1, 0));
    add_row(0, 1, 0, 0, make_req(prcb_pkg::OP_CODE, 0, 0, 8'h11), ov(0, 1, 0));
    add_row(0, 1, 0, 0, make_req(prcb_pkg::OP_START, 0, 0, 0), ov(0, 1, 0));
    add_row(0, 1, 0, 0, make_req(prcb_pkg::OP_CODE, 0, 0, 8'h0f), ov(0, 1, 0));
    add_row(0, 1, 0, 0, make_req(prcb_pkg::OP_CODE, 0, 0, 8'h10), ov(0, 1, 0));
    add_row(0, 0, 0, 0, make_req(prcb_pkg::OP_CODE, 0, 0, 8'h5f), '0);
    add_row(0, 0, 0, 0, make_req(prcb_pkg::OP_CODE, 0, 0, 8'h00), '0);
    add_row(0, 0, 0, 0, make_req(prcb_pkg::OP_READ, 5, 0, 0), '0);
    // Top sprite band, mirrored from the last corner with zero width.
    add_row(1, 0, prcb_pkg::REG_SPRITE_PR, 8'h0f, '0, '0);
    add_row(1, 0, prcb_pkg::REG_MIRROR, 8'h01, '0, '0);
    add_row(1, 0, prcb_pkg::REG_CEL_W, 8'h00, '0, '0);
    add_row(1, 0, prcb_pkg::REG_POS_X, 8'hff, '0, '0);
    add_row(1, 0, prcb_pkg::REG_POS_Y, 8'hff, '0, '0);
    add_row(0, 0, 0, 0, make_req(prcb_pkg::OP_START, 0, 0, 0), '0);
    add_row(0, 0, 0, 0, make_req(prcb_pkg::OP_CODE, 0, 0, 8'hff), '0);
    // Mirrored run leaving the store at its start; zero height finishes at once.
    add_row(1, 0, prcb_pkg::REG_POS_X, 8'h00, '0, '0);
    add_row(1, 0, prcb_pkg::REG_POS_Y, 8'h00, '0, '0);
    add_row(1, 0, prcb_pkg::REG_CEL_W, 8'h01, '0, '0);
    add_row(1, 0, prcb_pkg::REG_TRANSP, 8'h0f, '0, '0);
    add_row(0, 0, 0, 0, make_req(prcb_pkg::OP_START, 0, 0, 0), '0);
    add_row(0, 0, 0, 0, make_req(prcb_pkg::OP_CODE, 0, 0, 8'h25), '0);
    add_row(1, 0, prcb_pkg::REG_CEL_H, 8'h00, '0, '0);
    add_row(0, 1, 0, 0, make_req(prcb_pkg::OP_START, 0, 0, 0), ov(0, 1, 1));
    add_row(0, 1, 0, 0, make_req(prcb_pkg::OP_CODE, 0, 0, 8'h00), ov(0, 1, 1));
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_reg(dir_rows[i].idx, dir_rows[i].cval);
      else send_req(dir_rows[i].req, dir_rows[i].known, dir_rows[i].exp_val, 1'b1);
    end

    // Random phases: new settings while idle, then cels with bus traffic and noise.
    n_sent = 0;
    while (n_sent < RAND_ITEMS) begin
      write_reg(prcb_pkg::REG_POS_X,
                ($urandom_range(0, 4) == 0) ? 8'hff : 8'($urandom_range(0, 170)));
      write_reg(prcb_pkg::REG_POS_Y, 8'h00);
      write_reg(prcb_pkg::REG_SPRITE_PR, 8'($urandom_range(0, 15)));
      write_reg(prcb_pkg::REG_TRANSP, 8'($urandom_range(0, 15)));
      write_reg(prcb_pkg::REG_MIRROR, 8'($urandom_range(0, 1)));
      case ($urandom_range(0, 5))
        0: write_reg(prcb_pkg::REG_CEL_W, 8'h00);
        1: write_reg(prcb_pkg::REG_CEL_W, 8'd159);
        2: write_reg(prcb_pkg::REG_CEL_W, 8'd160);
        default: write_reg(prcb_pkg::REG_CEL_W, 8'($urandom_range(1, 40)));
      endcase
      case ($urandom_range(0, 7))
        0: write_reg(prcb_pkg::REG_CEL_H, 8'h00);
        1: write_reg(prcb_pkg::REG_CEL_H, 8'hff);
        2: write_reg(prcb_pkg::REG_CEL_H, 8'd168);
        default: write_reg(prcb_pkg::REG_CEL_H, 8'($urandom_range(1, 4)));
      endcase
      k = 0;
      while (k < 110 && n_sent < RAND_ITEMS) begin
        if (!stalled && n_sent >= stall_at) begin
          stalled = 1;
          stall_req = 1'b1;
        end
        if ($urandom_range(0, 6) == 0) begin
          a = rand_addr();
          it.action = 2'($urandom_range(0, 2));
          it.pixel_addr = 15'(a);
          it.pixel_data = band_pixel(a);
          it.code_byte = 8'($urandom_range(0, 255));
          send_req(it, 1'b0, '0, 1'b1);
          k++;
        end else begin
          send_req(make_req(prcb_pkg::OP_START, 0, 0, 0), 1'b0, '0, 1'b1);
          rows = (r_celh == 0) ? 1 : $urandom_range(1, (r_celh > 3) ? 3 : int'(r_celh));
          for (int r = 0; r < rows; r++) begin
            runs = $urandom_range(0, 4);
            for (int q = 0; q < runs; q++) begin
              if ($urandom_range(0, 4) == 0) begin
                a = rand_addr();
                send_req(make_req(prcb_pkg::op_e'($urandom_range(0, 1)), a,
                                  band_pixel(a), 0), 1'b0, '0, 1'b1);
              end
              send_req(make_req(prcb_pkg::OP_CODE, 0, 0,
                                {4'($urandom_range(0, 15)),
                                 ($urandom_range(0, 9) == 0) ? 4'h0
                                                             : 4'($urandom_range(1, 15))}),
                       1'b0, '0, 1'b1);
            end
            send_req(make_req(prcb_pkg::OP_CODE, 0, 0, 8'h00), 1'b0, '0, 1'b1);
          end
          k += 2 + rows * 3;
        end
      end
    end
    push <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk_i);
    if (pending_results.size() != 0) mismatches++;
    $display("Checked %0d results over %0d random requests and %0d cels.",
             n_checked, n_sent, n_cels);
    $display("Pixels drawn by the model: %0d, control-line look-downs: %0d.",
             n_drawn, n_lookdowns);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
